// ----- hdl/dtde_pkg.sv -----
// ----------------------------------------------------------------------------
// dtde_pkg
// Types, constants and calendar helpers shared by the date and time digit
// editor modules.
// ----------------------------------------------------------------------------
package dtde_pkg;

  // year field width, the year wraps modulo 2**YEAR_BITS
  localparam int YEAR_BITS = 12;

  // opcode values
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_BUTTON = 1'b1;

  // cursor positions
  localparam logic [3:0] POS_YEAR_THOU = 4'd0;
  localparam logic [3:0] POS_YEAR_HUND = 4'd1;
  localparam logic [3:0] POS_YEAR_TENS = 4'd2;
  localparam logic [3:0] POS_YEAR_ONES = 4'd3;
  localparam logic [3:0] POS_MON_TENS  = 4'd4;
  localparam logic [3:0] POS_MON_ONES  = 4'd5;
  localparam logic [3:0] POS_DAY_TENS  = 4'd6;
  localparam logic [3:0] POS_DAY_ONES  = 4'd7;
  localparam logic [3:0] POS_WEEKDAY   = 4'd8;
  localparam logic [3:0] POS_HOUR_TENS = 4'd9;
  localparam logic [3:0] POS_HOUR_ONES = 4'd10;
  localparam logic [3:0] POS_MIN_TENS  = 4'd11;
  localparam logic [3:0] POS_MIN_ONES  = 4'd12;
  localparam logic [3:0] POS_SET       = 4'd13;

  // month codes used by the length lookup
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;

  // number of multiples of 25 that fit in the year divided by four
  localparam int MUL25_CNT = ((1 << (YEAR_BITS - 2)) - 1) / 25 + 1;

  // input word
  typedef struct packed {
    logic                 opcode;
    logic                 press_up;
    logic                 press_down;
    logic                 press_next;
    logic                 press_back;
    logic [YEAR_BITS-1:0] load_year;
    logic [3:0]           load_month;
    logic [4:0]           load_day;
    logic [2:0]           load_weekday;
    logic [4:0]           load_hours;
    logic [5:0]           load_minutes;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [YEAR_BITS-1:0] year;
    logic [3:0]           month;
    logic [4:0]           day;
    logic [2:0]           weekday;
    logic [4:0]           hours;
    logic [5:0]           minutes;
    logic [3:0]           cursor;
    logic                 leave;
    logic                 commit;
  } out_word_t;

  // editor state
  typedef struct packed {
    logic [YEAR_BITS-1:0] year;
    logic [3:0]           month;
    logic [4:0]           day;
    logic [2:0]           weekday;
    logic [4:0]           hours;
    logic [5:0]           minutes;
    logic [3:0]           cursor;
  } cal_t;

  // true when v is a multiple of 25, a row of constant compares
  function automatic logic is_mul25(input logic [YEAR_BITS-3:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < MUL25_CNT; k++) begin
      if (v == (YEAR_BITS-2)'(k * 25)) hit = 1'b1;
    end
    return hit;
  endfunction

  // gregorian leap year: by 4, and not by 100 unless by 400
  function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
    logic by4;
    logic by100;
    logic by400;
    by4   = (y[1:0] == 2'd0);
    by100 = by4 && is_mul25(y[YEAR_BITS-1:2]);
    by400 = (y[3:0] == 4'd0) && is_mul25({2'b00, y[YEAR_BITS-1:4]});
    return by4 && (!by100 || by400);
  endfunction

  // days in a month
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    if (mon == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP || mon == MON_NOV) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ----- hdl/dtde_step.sv -----
// ----------------------------------------------------------------------------
// dtde_step
// Next-state logic for one word: cursor move, digit step and field wrap.
// ----------------------------------------------------------------------------
module dtde_step (
  input  dtde_pkg::cal_t      cal,
  input  dtde_pkg::in_word_t  word,
  output dtde_pkg::out_word_t res
);

  localparam int YB = dtde_pkg::YEAR_BITS;

  logic       is_btn;
  logic       up;
  logic       dn;
  logic [3:0] cur;
  logic       leave;
  logic       commit;

  logic [9:0] y_mag;
  logic [3:0] mo_mag;
  logic [3:0] d_mag;
  logic [3:0] w_mag;
  logic [3:0] h_mag;
  logic [3:0] mi_mag;

  logic signed [YB+1:0] y_d;
  logic signed [5:0]    mo_d;
  logic signed [6:0]    d_d;
  logic signed [4:0]    w_d;
  logic signed [6:0]    h_d;
  logic signed [7:0]    mi_d;

  logic [YB-1:0] y_b;
  logic [3:0]    mo_b;
  logic [4:0]    d_b;
  logic [2:0]    w_b;
  logic [4:0]    h_b;
  logic [5:0]    mi_b;

  logic signed [YB+1:0] y_s;
  logic signed [5:0]    mo_s;
  logic signed [6:0]    d_s;
  logic signed [4:0]    w_s;
  logic signed [6:0]    h_s;
  logic signed [7:0]    mi_s;

  logic [YB-1:0] y_w;
  logic          leap;
  logic [4:0]    len;
  logic signed [6:0] len_s;

  assign is_btn = (word.opcode == dtde_pkg::OP_BUTTON);
  assign dn     = is_btn && word.press_down;
  assign up     = is_btn && word.press_up && !word.press_down;

  // cursor: next first, then back
  always_comb begin
    cur    = cal.cursor;
    leave  = 1'b0;
    commit = 1'b0;
    if (!is_btn) begin
      cur = dtde_pkg::POS_YEAR_THOU;
    end else begin
      if (word.press_next) begin
        if (cur == dtde_pkg::POS_SET) begin
          leave  = 1'b1;
          commit = 1'b1;
        end else begin
          cur = cur + 4'd1;
        end
      end
      if (word.press_back) begin
        if (cur == dtde_pkg::POS_YEAR_THOU) begin
          leave  = 1'b1;
          commit = 1'b0;
        end else begin
          cur = cur - 4'd1;
        end
      end
    end
  end

  // digit weight under the new cursor
  always_comb begin
    y_mag  = '0;
    mo_mag = '0;
    d_mag  = '0;
    w_mag  = '0;
    h_mag  = '0;
    mi_mag = '0;
    unique case (cur)
      dtde_pkg::POS_YEAR_THOU: y_mag  = 10'd1000;
      dtde_pkg::POS_YEAR_HUND: y_mag  = 10'd100;
      dtde_pkg::POS_YEAR_TENS: y_mag  = 10'd10;
      dtde_pkg::POS_YEAR_ONES: y_mag  = 10'd1;
      dtde_pkg::POS_MON_TENS:  mo_mag = 4'd10;
      dtde_pkg::POS_MON_ONES:  mo_mag = 4'd1;
      dtde_pkg::POS_DAY_TENS:  d_mag  = 4'd10;
      dtde_pkg::POS_DAY_ONES:  d_mag  = 4'd1;
      dtde_pkg::POS_WEEKDAY:   w_mag  = 4'd1;
      dtde_pkg::POS_HOUR_TENS: h_mag  = 4'd10;
      dtde_pkg::POS_HOUR_ONES: h_mag  = 4'd1;
      dtde_pkg::POS_MIN_TENS:  mi_mag = 4'd10;
      dtde_pkg::POS_MIN_ONES:  mi_mag = 4'd1;
      default: ;
    endcase
  end

  // signed deltas, zero on a load word
  assign y_d  = dn ? -$signed({{(YB-8){1'b0}}, y_mag}) :
                (up ? $signed({{(YB-8){1'b0}}, y_mag}) : '0);
  assign mo_d = dn ? -$signed({2'b00, mo_mag}) : (up ? $signed({2'b00, mo_mag}) : '0);
  assign d_d  = dn ? -$signed({3'b000, d_mag}) : (up ? $signed({3'b000, d_mag}) : '0);
  assign w_d  = dn ? -$signed({1'b0, w_mag})   : (up ? $signed({1'b0, w_mag})   : '0);
  assign h_d  = dn ? -$signed({3'b000, h_mag}) : (up ? $signed({3'b000, h_mag}) : '0);
  assign mi_d = dn ? -$signed({4'b0000, mi_mag}) : (up ? $signed({4'b0000, mi_mag}) : '0);

  // base values: stored state or loaded time
  assign y_b  = is_btn ? cal.year    : word.load_year;
  assign mo_b = is_btn ? cal.month   : word.load_month;
  assign d_b  = is_btn ? cal.day     : word.load_day;
  assign w_b  = is_btn ? cal.weekday : word.load_weekday;
  assign h_b  = is_btn ? cal.hours   : word.load_hours;
  assign mi_b = is_btn ? cal.minutes : word.load_minutes;

  // raw signed sums
  assign y_s  = $signed({2'b00, y_b}) + y_d;
  assign mo_s = $signed({2'b00, mo_b}) + mo_d;
  assign d_s  = $signed({2'b00, d_b}) + d_d;
  assign w_s  = $signed({2'b00, w_b}) + w_d;
  assign h_s  = $signed({2'b00, h_b}) + h_d;
  assign mi_s = $signed({2'b00, mi_b}) + mi_d;

  // year wraps by dropping the upper bits
  assign y_w   = y_s[YB-1:0];
  assign leap  = dtde_pkg::is_leap(y_w);

  // wrap each field with one add or subtract
  always_comb begin
    logic signed [5:0] mo_t;
    logic signed [6:0] d_t;
    logic signed [4:0] w_t;
    logic signed [6:0] h_t;
    logic signed [7:0] mi_t;

    w_t = w_s;
    if (w_t < 5'sd0) w_t = w_t + 5'sd7;
    else if (w_t >= 5'sd7) w_t = w_t - 5'sd7;

    h_t = h_s;
    if (h_t < 7'sd0) h_t = h_t + 7'sd24;
    else if (h_t >= 7'sd24) h_t = h_t - 7'sd24;

    mi_t = mi_s;
    if (mi_t < 8'sd0) mi_t = mi_t + 8'sd60;
    else if (mi_t >= 8'sd60) mi_t = mi_t - 8'sd60;

    mo_t = mo_s;
    if (mo_t > 6'sd12) mo_t = mo_t - 6'sd12;
    else if (mo_t < 6'sd1) mo_t = mo_t + 6'sd12;

    len   = dtde_pkg::month_len(mo_t[3:0], leap);
    len_s = $signed({2'b00, len});
    d_t   = d_s;
    if (d_t > len_s) d_t = d_t - len_s;
    else if (d_t < 7'sd1) d_t = d_t + len_s;

    res.year    = y_w;
    res.month   = mo_t[3:0];
    res.day     = d_t[4:0];
    res.weekday = w_t[2:0];
    res.hours   = h_t[4:0];
    res.minutes = mi_t[5:0];
    res.cursor  = cur;
    res.leave   = leave;
    res.commit  = commit;
  end

endmodule

// ----- hdl/date_time_digit_editor.sv -----
// ----------------------------------------------------------------------------
// date_time_digit_editor
// Four-button date and time setting editor with load and button words.
// ----------------------------------------------------------------------------
//  channel | ports                         | word
//  --------+-------------------------------+--------------------------
//  input   | in_valid, in_ready, in_word   | load or button event
//  output  | out_valid, out_ready, out_word| edited time, cursor, exit
//
//  A word is registered at the input, passes through the combinational
//  edit logic between the input and result registers, and lands in the
//  result register, which raises out_valid. One word per cycle is
//  sustained while out_ready stays high. A stalled output holds its word
//  while the input register still takes one more. rst_n is synchronous and
//  returns the editor to year 0, January 1st, 00:00, cursor at 0.
// ----------------------------------------------------------------------------
module date_time_digit_editor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtde_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dtde_pkg::out_word_t out_word
);

  logic                in_v_r;
  dtde_pkg::in_word_t  in_word_r;
  logic                out_v_r;
  dtde_pkg::out_word_t out_word_r;
  dtde_pkg::cal_t      cal_r;
  dtde_pkg::out_word_t res_nxt;
  logic                fire;

  // word moves to the result register when that register frees up
  assign fire     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || fire;

  // edit logic
  dtde_step u_step (
    .cal  (cal_r),
    .word (in_word_r),
    .res  (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_word;
    end
  end

  // editor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.year    <= '0;
      cal_r.month   <= 4'd1;
      cal_r.day     <= 5'd1;
      cal_r.weekday <= '0;
      cal_r.hours   <= '0;
      cal_r.minutes <= '0;
      cal_r.cursor  <= dtde_pkg::POS_YEAR_THOU;
    end else if (fire) begin
      cal_r.year    <= res_nxt.year;
      cal_r.month   <= res_nxt.month;
      cal_r.day     <= res_nxt.day;
      cal_r.weekday <= res_nxt.weekday;
      cal_r.hours   <= res_nxt.hours;
      cal_r.minutes <= res_nxt.minutes;
      cal_r.cursor  <= res_nxt.cursor;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

endmodule
